/* rtl/color_gradient_table_builder_defines.svh */
// assertion helpers for the gradient table builder
`ifndef COLOR_GRADIENT_TABLE_BUILDER_DEFINES_SVH
`define COLOR_GRADIENT_TABLE_BUILDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CGT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CGT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cgt_pkg.sv */
package cgt_pkg;

  // table geometry
  localparam int TABLE_SIZE = 256;
  localparam int MAX_POINTS = 16;
  localparam int POS_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PT_CW      = $clog2(MAX_POINTS + 1);
  localparam int MAP_W      = POS_W + $clog2(TABLE_SIZE + 1);
  localparam int DIV_CW     = $clog2(FRAC_W);

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] mode_t;
  typedef logic [31:0] rgba_t;

  // transaction kinds
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_BUILD  = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;

  // result status codes
  localparam status_t STATUS_DONE   = 2'd0;
  localparam status_t STATUS_DUP    = 2'd1;
  localparam status_t STATUS_REJECT = 2'd2;
  localparam status_t STATUS_EMPTY  = 2'd3;

  // interpolation modes
  localparam mode_t MODE_LINEAR = 2'd0;
  localparam mode_t MODE_EXP    = 2'd1;
  localparam mode_t MODE_HOLD   = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    rgba_t            color;
  } point_t;

  // palette index of a position, clamped to the last entry
  function automatic logic [IDX_W-1:0] map_index(input logic [POS_W-1:0] pos);
    logic [MAP_W-1:0] prod;
    logic [MAP_W-1:0] idx;
    prod = MAP_W'(pos) * MAP_W'(TABLE_SIZE);
    idx  = prod >> FRAC_W;
    if (idx >= MAP_W'(TABLE_SIZE)) begin
      return IDX_W'(TABLE_SIZE - 1);
    end
    return idx[IDX_W-1:0];
  endfunction

endpackage

/* rtl/cgt_if.sv */
// command channel
interface cgt_in_if import cgt_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [POS_W-1:0] position;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic [7:0]       alpha;
  logic [7:0]       entry_index;

  modport source (output valid, kind, position, red, green, blue, alpha, entry_index,
                  input ready);
  modport sink (input valid, kind, position, red, green, blue, alpha, entry_index,
                output ready);
endinterface

// result channel
interface cgt_out_if import cgt_pkg::*; ();
  logic       valid;
  logic       ready;
  status_t    status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, status, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, status, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface

// mode register write channel
interface cgt_cfg_if import cgt_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t interp_mode;

  modport source (output valid, interp_mode, input ready);
  modport sink (input valid, interp_mode, output ready);
endinterface

/* rtl/color_gradient_table_builder.sv */
// Gradient palette builder: a sorted store of up to 16 color points and a
// 256-entry RGBA palette, both held in synchronous RAMs.
// in_ch carries one command per transaction: insert a point, build the
// palette, or read one palette entry. out_ch returns exactly one result per
// command (status plus the entry color for reads). cfg_ch writes the
// interpolation mode and is always ready; write it only while idle.
// One command is worked on at a time; in_ch is ready again as soon as the
// result sits in the output register, so the next command is taken while
// the previous result waits for the receiver. A stalled receiver only
// holds back the result after that.
// A read passes S_RD_PAL and S_DONE; an insert scans for the slot, then shifts
// the points above it up. Build walks the points and, per filled entry,
// copies the start color in hold mode; linear mode runs a restoring divider
// (16-bit quotient, one quotient bit per cycle) and then mixes the three
// channels, and exponential mode adds a fifth root search through one
// multiplier chain.
// Reset empties the point store and the palette (per-entry valid bits, no
// clearing pass) and sets linear mode.
`include "color_gradient_table_builder_defines.svh"

module color_gradient_table_builder import cgt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cgt_in_if.sink     in_ch,
  cgt_out_if.source  out_ch,
  cgt_cfg_if.sink    cfg_ch
);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_INS_PLACE, S_SHF_RD, S_SHF_WR, S_INS_WR,
    S_TAIL_RD, S_TAIL_CHK, S_PT_RD, S_PT_USE, S_FILL_START, S_DIV, S_ROOT,
    S_MIX, S_FILL_WR, S_RD_PAL, S_DONE
  } state_t;

  state_t               state_r;
  mode_t                mode_r;
  logic [POS_W-1:0]     pos_in_r;
  rgba_t                col_in_r;
  logic                 idx_ok_r;
  logic [PT_CW-1:0]     cnt_r;
  logic [PT_CW-1:0]     ptr_r;
  logic [PT_CW-1:0]     ins_j_r;
  status_t              res_status_r;
  rgba_t                res_entry_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  rgba_t                out_entry_r;
  logic                 extra_r;
  logic                 ext_sel_r;
  rgba_t                extra_col_r;
  logic [IDX_W-1:0]     last_r;
  logic [IDX_W-1:0]     next_r;
  logic [IDX_W-1:0]     fill_i_r;
  rgba_t                last_col_r;
  rgba_t                span_a_r;
  rgba_t                span_b_r;
  rgba_t                acc_r;
  logic [IDX_W-1:0]     rem_r;
  logic [IDX_W-1:0]     den_r;
  logic [FRAC_W-1:0]    quot_r;
  logic [DIV_CW-1:0]    div_cnt_r;
  logic [FRAC_W-1:0]    p_r;
  logic [FRAC_W-1:0]    root_q_r;
  logic [FRAC_W-1:0]    t_r;
  logic [FRAC_W-1:0]    w_r;
  logic [DIV_CW-1:0]    bit_r;
  logic [2:0]           phase_r;
  logic [2*FRAC_W-1:0]  sq_r;
  logic [4*FRAC_W-1:0]  q4_r;
  logic [3*FRAC_W-1:0]  lo_r;
  logic [3*FRAC_W-1:0]  hi_r;
  logic [1:0]           ch_r;

  // point store and palette RAMs
  point_t               pt_mem [MAX_POINTS];
  point_t               pt_q_r;
  logic [PT_AW-1:0]     pt_ra;
  logic                 pt_we;
  logic [PT_AW-1:0]     pt_wa;
  point_t               pt_wd;
  rgba_t                pal_mem [TABLE_SIZE];
  rgba_t                pal_q_r;
  logic                 pal_vq_r;
  logic [TABLE_SIZE-1:0] pal_valid_r;
  logic                 pal_we;
  logic [IDX_W-1:0]     pal_wa;
  rgba_t                pal_wd;
  logic [IDX_W-1:0]     pal_ra;

  // combinational helpers
  logic [PT_CW-1:0]     ptr_m1;
  logic [PT_CW-1:0]     cnt_m1;
  logic                 tail_append;
  point_t               cur_pt;
  logic [IDX_W-1:0]     cur_idx;
  rgba_t                cur_ca;
  logic                 span_needed;
  logic [IDX_W:0]       rem2;
  logic                 d_ge;
  logic [IDX_W-1:0]     rem_sub;
  logic [FRAC_W-1:0]    quot_fin;
  logic [5*FRAC_W-1:0]  t5;
  logic                 root_fits;
  logic [FRAC_W-1:0]    root_q_nxt;
  logic [7:0]           mix_a;
  logic [7:0]           mix_b;
  logic signed [8:0]    mix_d;
  logic signed [25:0]   mix_prod;
  logic signed [9:0]    mix_sum;

  assign ptr_m1 = ptr_r - PT_CW'(1);
  assign cnt_m1 = cnt_r - PT_CW'(1);
  assign tail_append = (pt_q_r.pos != POS_ONE) && (cnt_r < PT_CW'(MAX_POINTS));

  // current point of the build walk, or the synthetic end point
  always_comb begin
    if (ext_sel_r) begin
      cur_pt.pos   = POS_ONE;
      cur_pt.color = extra_col_r;
    end else begin
      cur_pt = pt_q_r;
    end
  end

  assign cur_idx     = map_index(cur_pt.pos);
  assign cur_ca      = (ptr_r == '0) ? cur_pt.color : last_col_r;
  assign span_needed = {1'b0, cur_idx} > ({1'b0, last_r} + (IDX_W+1)'(1));

  // restoring divider step
  assign rem2     = {rem_r, 1'b0};
  assign d_ge     = rem2 >= {1'b0, den_r};
  assign rem_sub  = IDX_W'(rem2 - {1'b0, den_r});
  assign quot_fin = {quot_r[FRAC_W-2:0], d_ge};

  // fifth root trial compare: t^5 <= p * 2^64
  assign t5         = {hi_r, {(2*FRAC_W){1'b0}}} + (5*FRAC_W)'(lo_r);
  assign root_fits  = t5 <= {p_r, {(4*FRAC_W){1'b0}}};
  assign root_q_nxt = root_fits ? t_r : root_q_r;

  // per-channel blend: a + floor((b - a) * w / 65536)
  assign mix_a    = span_a_r[8*ch_r +: 8];
  assign mix_b    = span_b_r[8*ch_r +: 8];
  assign mix_d    = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
  assign mix_prod = 26'(mix_d) * 26'($signed({1'b0, w_r}));
  assign mix_sum  = $signed({2'b00, mix_a}) + $signed(mix_prod[25:16]);

  // point store port control
  always_comb begin
    pt_ra = ptr_r[PT_AW-1:0];
    pt_we = 1'b0;
    pt_wa = ptr_r[PT_AW-1:0];
    pt_wd = pt_q_r;
    case (state_r)
      S_SHF_RD:  pt_ra = ptr_m1[PT_AW-1:0];
      S_TAIL_RD: pt_ra = cnt_m1[PT_AW-1:0];
      S_SHF_WR:  pt_we = 1'b1;
      S_INS_WR: begin
        pt_we       = 1'b1;
        pt_wa       = ins_j_r[PT_AW-1:0];
        pt_wd.pos   = pos_in_r;
        pt_wd.color = col_in_r;
      end
      S_TAIL_CHK: begin
        pt_we       = tail_append;
        pt_wa       = cnt_r[PT_AW-1:0];
        pt_wd.pos   = POS_ONE;
        pt_wd.color = pt_q_r.color;
      end
      default: ;
    endcase
  end

  // palette port control
  always_comb begin
    pal_ra = IDX_W'(in_ch.entry_index);
    pal_we = 1'b0;
    pal_wa = cur_idx;
    pal_wd = cur_pt.color;
    case (state_r)
      S_PT_USE: pal_we = 1'b1;
      S_FILL_WR: begin
        pal_we = 1'b1;
        pal_wa = fill_i_r;
        pal_wd = {8'hFF, acc_r[23:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_q_r <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_wa] <= pal_wd;
    end
    pal_q_r  <= pal_mem[pal_ra];
    pal_vq_r <= pal_valid_r[pal_ra];
  end

  // entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_valid_r <= '0;
    end else if (pal_we) begin
      pal_valid_r[pal_wa] <= 1'b1;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_LINEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= cfg_ch.interp_mode;
      end

      // result register: loaded from done, cleared when taken
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            pos_in_r    <= in_ch.position;
            col_in_r    <= {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};
            idx_ok_r    <= 32'(in_ch.entry_index) < TABLE_SIZE;
            ptr_r       <= '0;
            res_entry_r <= '0;
            unique case (in_ch.kind)
              KIND_INSERT: begin
                if (in_ch.position > POS_ONE) begin
                  res_status_r <= STATUS_REJECT;
                  state_r      <= S_DONE;
                end else if (cnt_r == '0) begin
                  ins_j_r <= '0;
                  state_r <= S_INS_PLACE;
                end else begin
                  state_r <= S_INS_RD;
                end
              end
              KIND_BUILD: begin
                if (cnt_r == '0) begin
                  res_status_r <= STATUS_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_TAIL_RD;
                end
              end
              KIND_READ: state_r <= S_RD_PAL;
              default: begin
                res_status_r <= STATUS_REJECT;
                state_r      <= S_DONE;
              end
            endcase
          end
        end

        // ordered scan for duplicate and insertion slot
        S_INS_RD: state_r <= S_INS_CHK;
        S_INS_CHK: begin
          if (pt_q_r.pos == pos_in_r) begin
            res_status_r <= STATUS_DUP;
            state_r      <= S_DONE;
          end else if (pt_q_r.pos > pos_in_r) begin
            ins_j_r <= ptr_r;
            state_r <= S_INS_PLACE;
          end else if (ptr_r + PT_CW'(1) == cnt_r) begin
            ins_j_r <= cnt_r;
            state_r <= S_INS_PLACE;
          end else begin
            ptr_r   <= ptr_r + PT_CW'(1);
            state_r <= S_INS_RD;
          end
        end
        S_INS_PLACE: begin
          if (cnt_r == PT_CW'(MAX_POINTS)) begin
            res_status_r <= STATUS_REJECT;
            state_r      <= S_DONE;
          end else begin
            ptr_r   <= cnt_r;
            state_r <= (cnt_r == ins_j_r) ? S_INS_WR : S_SHF_RD;
          end
        end

        // move entries up one slot, top first
        S_SHF_RD: state_r <= S_SHF_WR;
        S_SHF_WR: begin
          ptr_r   <= ptr_m1;
          state_r <= (ptr_m1 == ins_j_r) ? S_INS_WR : S_SHF_RD;
        end
        S_INS_WR: begin
          cnt_r        <= cnt_r + PT_CW'(1);
          res_status_r <= STATUS_DONE;
          state_r      <= S_DONE;
        end

        // end point at 1.0
        S_TAIL_RD: state_r <= S_TAIL_CHK;
        S_TAIL_CHK: begin
          extra_r     <= !tail_append && (pt_q_r.pos != POS_ONE);
          extra_col_r <= pt_q_r.color;
          ext_sel_r   <= 1'b0;
          last_r      <= '0;
          ptr_r       <= '0;
          if (tail_append) begin
            cnt_r <= cnt_r + PT_CW'(1);
          end
          state_r <= S_PT_RD;
        end

        // walk over the points
        S_PT_RD: begin
          if (ptr_r < cnt_r) begin
            state_r <= S_PT_USE;
          end else if (extra_r) begin
            ext_sel_r <= 1'b1;
            extra_r   <= 1'b0;
            state_r   <= S_PT_USE;
          end else begin
            res_status_r <= STATUS_DONE;
            state_r      <= S_DONE;
          end
        end
        S_PT_USE: begin
          if (span_needed) begin
            next_r   <= cur_idx;
            span_a_r <= cur_ca;
            span_b_r <= cur_pt.color;
            fill_i_r <= last_r + IDX_W'(1);
            state_r  <= S_FILL_START;
          end else begin
            last_r     <= cur_idx;
            last_col_r <= cur_pt.color;
            if (!ext_sel_r) begin
              ptr_r <= ptr_r + PT_CW'(1);
            end
            ext_sel_r <= 1'b0;
            state_r   <= S_PT_RD;
          end
        end

        // one filled entry
        S_FILL_START: begin
          if (mode_r == MODE_LINEAR || mode_r == MODE_EXP) begin
            rem_r     <= fill_i_r - last_r;
            den_r     <= next_r - last_r;
            div_cnt_r <= DIV_CW'(FRAC_W - 1);
            state_r   <= S_DIV;
          end else begin
            acc_r   <= span_a_r;
            state_r <= S_FILL_WR;
          end
        end
        S_DIV: begin
          rem_r     <= d_ge ? rem_sub : rem2[IDX_W-1:0];
          quot_r    <= quot_fin;
          div_cnt_r <= div_cnt_r - DIV_CW'(1);
          if (div_cnt_r == '0) begin
            if (mode_r == MODE_EXP) begin
              p_r      <= quot_fin;
              root_q_r <= '0;
              bit_r    <= DIV_CW'(FRAC_W - 1);
              phase_r  <= '0;
              state_r  <= S_ROOT;
            end else begin
              w_r     <= quot_fin;
              ch_r    <= '0;
              state_r <= S_MIX;
            end
          end
        end
        S_ROOT: begin
          case (phase_r)
            3'd0: begin
              t_r     <= root_q_r | (FRAC_W'(1) << bit_r);
              phase_r <= 3'd1;
            end
            3'd1: begin
              sq_r    <= (2*FRAC_W)'(t_r) * (2*FRAC_W)'(t_r);
              phase_r <= 3'd2;
            end
            3'd2: begin
              q4_r    <= (4*FRAC_W)'(sq_r) * (4*FRAC_W)'(sq_r);
              phase_r <= 3'd3;
            end
            3'd3: begin
              lo_r    <= (3*FRAC_W)'(q4_r[2*FRAC_W-1:0]) * (3*FRAC_W)'(t_r);
              phase_r <= 3'd4;
            end
            3'd4: begin
              hi_r    <= (3*FRAC_W)'(q4_r[4*FRAC_W-1:2*FRAC_W]) * (3*FRAC_W)'(t_r);
              phase_r <= 3'd5;
            end
            default: begin
              root_q_r <= root_q_nxt;
              phase_r  <= 3'd0;
              if (bit_r == '0) begin
                w_r     <= root_q_nxt;
                ch_r    <= '0;
                state_r <= S_MIX;
              end else begin
                bit_r <= bit_r - DIV_CW'(1);
              end
            end
          endcase
        end
        S_MIX: begin
          acc_r[8*ch_r +: 8] <= mix_sum[7:0];
          if (ch_r == 2'd2) begin
            state_r <= S_FILL_WR;
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        S_FILL_WR: begin
          if (fill_i_r + IDX_W'(1) == next_r) begin
            last_r     <= next_r;
            last_col_r <= span_b_r;
            if (!ext_sel_r) begin
              ptr_r <= ptr_r + PT_CW'(1);
            end
            ext_sel_r <= 1'b0;
            state_r   <= S_PT_RD;
          end else begin
            fill_i_r <= fill_i_r + IDX_W'(1);
            state_r  <= S_FILL_START;
          end
        end

        // palette read, data registered at accept
        S_RD_PAL: begin
          res_status_r <= idx_ok_r ? STATUS_DONE : STATUS_REJECT;
          res_entry_r  <= (idx_ok_r && pal_vq_r) ? pal_q_r : '0;
          state_r      <= S_DONE;
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_status_r <= res_status_r;
            out_entry_r  <= res_entry_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_red   = out_entry_r[7:0];
  assign out_ch.out_green = out_entry_r[15:8];
  assign out_ch.out_blue  = out_entry_r[23:16];
  assign out_ch.out_alpha = out_entry_r[31:24];

  // checks
  `CGT_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= PT_CW'(MAX_POINTS), "point count overflow")
  `CGT_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "result without done")
  `CGT_ASSERT_NXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `CGT_ASSERT_IMP(a_fill_span, clk, rst_n, state_r == S_FILL_WR, (fill_i_r > last_r) && (fill_i_r < next_r), "fill outside span")

endmodule

/* dv/tb_color_gradient_table_builder.sv */
`timescale 1ns / 1ps

module tb_color_gradient_table_builder;
  import cgt_pkg::*;

  // codes the package leaves unnamed
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam mode_t MODE_HOLD_ALT = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES = 8;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] position;
    rgba_t            color;
    logic [7:0]       entry_index;
  } command_t;

  typedef struct packed {
    status_t status;
    rgba_t   color;
  } answer_t;

  typedef struct {
    command_t cmd;
    bit       typed;
    answer_t  typed_answer;
  } stim_row_t;

  logic clk;
  logic rst_n;

  cgt_in_if  in_ch ();
  cgt_out_if out_ch ();
  cgt_cfg_if cfg_ch ();

  color_gradient_table_builder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow state of the block
  logic [POS_W-1:0] shadow_pos[MAX_POINTS];
  rgba_t            shadow_col[MAX_POINTS];
  int               shadow_count;
  rgba_t            shadow_palette[TABLE_SIZE];
  mode_t            shadow_mode;

  answer_t   pending_answers[$];
  stim_row_t directed_rows[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #100ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // floor(65536 * (p/65536)^0.2) by bitwise search on q^5 <= p * 2^64
  function automatic logic [15:0] fifth_root(input logic [15:0] p);
    logic [15:0] q;
    logic [15:0] t;
    logic [95:0] t5;
    logic [95:0] lim;
    q = '0;
    lim = 96'({p, 64'd0});
    for (int b = 15; b >= 0; b--) begin
      t = q | (16'd1 << b);
      t5 = 96'(t) * 96'(t) * 96'(t) * 96'(t) * 96'(t);
      if (t5 <= lim) q = t;
    end
    return q;
  endfunction

  function automatic int palette_slot(input logic [POS_W-1:0] pos);
    int idx;
    idx = (int'(pos) * TABLE_SIZE) >> 16;
    return (idx >= TABLE_SIZE) ? TABLE_SIZE - 1 : idx;
  endfunction

  // fill entries strictly between two mapped points
  function automatic void fill_gap(input int lo, input int hi, input rgba_t ca,
                                   input rgba_t cb);
    longint p;
    longint w;
    longint a;
    longint b;
    rgba_t  e;
    for (int i = lo + 1; i < hi; i++) begin
      p = (longint'(i - lo) << 16) / longint'(hi - lo);
      w = (shadow_mode == MODE_EXP) ? longint'(fifth_root(16'(p))) : p;
      e = 32'hFF00_0000;
      for (int c = 0; c < 3; c++) begin
        a = longint'(ca[8*c +: 8]);
        b = longint'(cb[8*c +: 8]);
        if (shadow_mode == MODE_LINEAR || shadow_mode == MODE_EXP)
          e[8*c +: 8] = 8'((a * (65536 - w) + b * w) >> 16);
        else
          e[8*c +: 8] = 8'(a);
      end
      shadow_palette[i] = e;
    end
  endfunction

  function automatic status_t build_palette();
    bit    extra;
    int    n;
    int    lo;
    int    hi;
    rgba_t lo_col;
    rgba_t col;
    logic [POS_W-1:0] pos;
    extra = 0;
    if (shadow_count == 0) return STATUS_EMPTY;
    if (shadow_pos[shadow_count-1] != POS_ONE) begin
      if (shadow_count < MAX_POINTS) begin
        shadow_pos[shadow_count] = POS_ONE;
        shadow_col[shadow_count] = shadow_col[shadow_count-1];
        shadow_count++;
      end else begin
        extra = 1;
      end
    end
    n = shadow_count;
    lo = 0;
    lo_col = shadow_col[0];
    for (int k = 0; k <= n; k++) begin
      if (k == n) begin
        if (!extra) break;
        pos = POS_ONE;
        col = shadow_col[n-1];
      end else begin
        pos = shadow_pos[k];
        col = shadow_col[k];
      end
      hi = palette_slot(pos);
      shadow_palette[hi] = col;
      if (hi > lo + 1) fill_gap(lo, hi, lo_col, col);
      lo = hi;
      lo_col = col;
    end
    return STATUS_DONE;
  endfunction

  function automatic status_t insert_point(input logic [POS_W-1:0] pos, input rgba_t col);
    int j;
    if (pos > POS_ONE) return STATUS_REJECT;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_pos[i] == pos) return STATUS_DUP;
    if (shadow_count >= MAX_POINTS) return STATUS_REJECT;
    j = 0;
    while (j < shadow_count && shadow_pos[j] < pos) j++;
    for (int k = shadow_count; k > j; k--) begin
      shadow_pos[k] = shadow_pos[k-1];
      shadow_col[k] = shadow_col[k-1];
    end
    shadow_pos[j] = pos;
    shadow_col[j] = col;
    shadow_count++;
    return STATUS_DONE;
  endfunction

  function automatic answer_t predict_answer(input command_t cmd);
    answer_t ans;
    ans = '{status: STATUS_REJECT, color: '0};
    case (cmd.kind)
      KIND_INSERT: ans.status = insert_point(cmd.position, cmd.color);
      KIND_BUILD:  ans.status = build_palette();
      KIND_READ: begin
        ans.status = STATUS_DONE;
        ans.color = shadow_palette[cmd.entry_index];
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic stim_row_t mk_row(input kind_t k, input int pos, input rgba_t col,
                                       input int idx, input bit typed = 0,
                                       input status_t st = STATUS_DONE,
                                       input rgba_t ecol = '0);
    stim_row_t r;
    r.cmd = '{kind: k, position: POS_W'(pos), color: col, entry_index: 8'(idx)};
    r.typed = typed;
    r.typed_answer = '{status: st, color: ecol};
    return r;
  endfunction

  // drive one transaction, update the shadow state on acceptance
  task automatic send_command(input command_t cmd, input bit typed, input answer_t typed_ans);
    answer_t ans;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= cmd.kind;
    in_ch.position    <= cmd.position;
    {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red} <= cmd.color;
    in_ch.entry_index <= cmd.entry_index;
    do @(posedge clk); while (!in_ch.ready);
    ans = predict_answer(cmd);
    pending_answers.push_back(typed ? typed_ans : ans);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.interp_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_mode = m;
  endtask

  function automatic command_t random_command();
    command_t cmd;
    int r;
    r = $urandom_range(99);
    cmd.position    = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    cmd.color       = $urandom();
    cmd.entry_index = 8'($urandom_range(0, 255));
    if (r < 3)       cmd.kind = KIND_BUILD;
    else if (r < 18) cmd.kind = KIND_INSERT;
    else if (r < 21) cmd.kind = KIND_UNUSED;
    else             cmd.kind = KIND_READ;
    if (cmd.kind == KIND_INSERT && $urandom_range(3) == 0)
      cmd.position = POS_W'($urandom_range(0, 65536));
    return cmd;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_ch.status);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.out_red !== want.color[7:0]) begin
          $display("%0t: red expected %0d actual %0d", $time, want.color[7:0], out_ch.out_red);
          error_count++;
        end
        if (out_ch.out_green !== want.color[15:8]) begin
          $display("%0t: green expected %0d actual %0d", $time, want.color[15:8],
                   out_ch.out_green);
          error_count++;
        end
        if (out_ch.out_blue !== want.color[23:16]) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.color[23:16],
                   out_ch.out_blue);
          error_count++;
        end
        if (out_ch.out_alpha !== want.color[31:24]) begin
          $display("%0t: alpha expected %0d actual %0d", $time, want.color[31:24],
                   out_ch.out_alpha);
          error_count++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // stimulus
  initial begin
    mode_t phase_modes[PHASES];
    int    per_phase;
    int    wait_cycles;
    phase_modes = '{MODE_LINEAR, MODE_EXP, MODE_HOLD, MODE_HOLD_ALT,
                    MODE_LINEAR, MODE_HOLD, MODE_EXP, MODE_LINEAR};
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    shadow_count   = 0;
    shadow_mode    = MODE_LINEAR;
    foreach (shadow_palette[i]) shadow_palette[i] = '0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_READ;
    in_ch.position     <= '0;
    in_ch.red          <= '0;
    in_ch.green        <= '0;
    in_ch.blue         <= '0;
    in_ch.alpha        <= '0;
    in_ch.entry_index  <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.interp_mode <= MODE_LINEAR;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, bad positions, same index, full store without an end point
    directed_rows.push_back(mk_row(KIND_READ, 0, '0, 255, 1, STATUS_DONE, '0));
    directed_rows.push_back(mk_row(KIND_BUILD, 0, '0, 0, 1, STATUS_EMPTY));
    directed_rows.push_back(mk_row(KIND_INSERT, 65537, 32'hFFFF_FFFF, 0, 1, STATUS_REJECT));
    directed_rows.push_back(mk_row(KIND_INSERT, 131071, '0, 0, 1, STATUS_REJECT));
    directed_rows.push_back(mk_row(KIND_INSERT, 300, 32'hFF00_00FF, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 256, 32'h0000_FF00, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 300, 32'h1234_5678, 0, 1, STATUS_DUP));
    directed_rows.push_back(mk_row(KIND_INSERT, 65535, 32'hFFFF_FFFF, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 512, 32'h00FF_0000, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 65280, 32'h0000_0000, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 700, 32'h80FF_FFFF, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 4096, 32'h7F00_FF00, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 12000, 32'hAA55_AA55, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 20000, 32'h55AA_55AA, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 32768, 32'h0F0F_0F0F, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 40000, 32'hF0F0_F0F0, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 50000, 32'h0102_0304, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 60000, 32'hFEFD_FCFB, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 61000, 32'h3366_99CC, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 65000, 32'hCC99_6633, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 62000, 32'h00FF_00FF, 0));
    directed_rows.push_back(mk_row(KIND_INSERT, 0, 32'hFFFF_FFFF, 0, 1, STATUS_REJECT));
    directed_rows.push_back(mk_row(KIND_INSERT, 65536, '0, 0, 1, STATUS_REJECT));
    directed_rows.push_back(mk_row(KIND_BUILD, 0, '0, 0));
    // no point maps to entry zero, so it stays clear
    directed_rows.push_back(mk_row(KIND_READ, 0, '0, 0, 1, STATUS_DONE, '0));
    directed_rows.push_back(mk_row(KIND_READ, 0, '0, 1));
    directed_rows.push_back(mk_row(KIND_READ, 0, '0, 255));
    directed_rows.push_back(mk_row(KIND_UNUSED, 131071, 32'hFFFF_FFFF, 255, 1,
                                   STATUS_REJECT));
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].typed,
                   directed_rows[i].typed_answer);
    drain_results();

    // random phases, each setting a mode and an idle pattern
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(phase_modes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        // halfway through phase 3, hold off until the block has answered everything
        if (ph == 3 && n == per_phase / 2) begin
          in_ch.valid <= 1'b0;
          while (pending_answers.size() != 0) @(posedge clk);
        end
        send_command(random_command(), 0, '0);
      end
      drain_results();
    end

    wait_cycles = 0;
    while (pending_answers.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
